// File: rtl/aescbc_pkg.sv
// Shared types and constants for the AES CBC block engine.
`default_nettype none
package aescbc_pkg;
    localparam int unsigned BlockW = 128;
    localparam int unsigned RkW = 32;

    typedef enum logic [2:0] {
        REG_KEY_A = 3'd0,
        REG_KEY_B = 3'd1,
        REG_KEY_C = 3'd2,
        REG_KEY_LEN = 3'd3,
        REG_DECRYPT = 3'd4,
        REG_CHAIN = 3'd5,
        REG_IV_HI = 3'd6,
        REG_IV_LO = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND
    } t_state;

    // Key expansion handshake between the top level and the expander.
    typedef struct packed {
        logic start;
        logic len192;
    } t_kx_ctrl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits 127-8i.
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        for (int i = 0; i < 16; i++) begin
            if (inv) begin
                src = (i + 12 * (i % 4)) % 16;
                r[127 - 8*i -: 8] = inv_sbox(byte_at(s, src));
            end else begin
                src = (i + 4 * (i % 4)) % 16;
                r[127 - 8*i -: 8] = sbox(byte_at(s, src));
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3, t, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c + 1);
            a2 = byte_at(s, 4*c + 2);
            a3 = byte_at(s, 4*c + 3);
            if (inv) begin
                // Preconditioning: inverse mix = forward mix of adjusted column.
                u = xt(xt(a0 ^ a2));
                v = xt(xt(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            t = a0 ^ a1 ^ a2 ^ a3;
            r[127 - 32*c      -: 8] = a0 ^ t ^ xt(a0 ^ a1);
            r[127 - 32*c - 8  -: 8] = a1 ^ t ^ xt(a1 ^ a2);
            r[127 - 32*c - 16 -: 8] = a2 ^ t ^ xt(a2 ^ a3);
            r[127 - 32*c - 24 -: 8] = a3 ^ t ^ xt(a3 ^ a0);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/aescbc_kexp.sv
// Key expander: one round-key word per cycle into the round-key memory.
`default_nettype none
module aescbc_kexp #(
    parameter int unsigned ROUND_KEY_WORDS = 52
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire aescbc_pkg::t_kx_ctrl i_ctrl,
    input  wire logic [191:0]         i_key,
    output logic                      o_busy,
    output logic                      o_we,
    output logic [$clog2(ROUND_KEY_WORDS)-1:0] o_waddr,
    output logic [31:0]               o_wdata
);
    localparam int unsigned AW = $clog2(ROUND_KEY_WORDS);

    // Sliding window of the last six words, newest in slot 0.
    logic [31:0] r_win [6];
    logic [31:0] n_win [6];
    logic [5:0]  r_idx, n_idx;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_rc, n_rc;
    logic        r_busy, n_busy, r_len;
    logic [5:0]  w_total;
    logic [31:0] w_new, w_t, w_rot;

    always_comb begin
        w_total = r_len ? 6'd52 : 6'd44;
        w_rot = {r_win[0][23:0], r_win[0][31:24]};
        w_t = r_win[0];
        if (r_phase == 3'd0) begin
            w_t = {aescbc_pkg::sbox(w_rot[31:24]) ^ r_rc, aescbc_pkg::sbox(w_rot[23:16]),
                   aescbc_pkg::sbox(w_rot[15:8]), aescbc_pkg::sbox(w_rot[7:0])};
        end
        w_new = (r_len ? r_win[5] : r_win[3]) ^ w_t;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx = r_idx;
        n_phase = r_phase;
        n_rc = r_rc;
        for (int k = 0; k < 6; k++) n_win[k] = r_win[k];
        o_we = 1'b0;
        o_wdata = w_new;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_idx = 6'd0;
            n_phase = 3'd0;
            n_rc = 8'h01;
        end else if (r_busy) begin
            o_we = (r_idx < 6'(ROUND_KEY_WORDS));
            if (r_idx < (r_len ? 6'd6 : 6'd4)) begin
                o_wdata = i_key[191 - 32*r_idx -: 32];
            end else if (r_phase == 3'd0) begin
                n_rc = aescbc_pkg::xt(r_rc);
            end
            n_win[0] = o_wdata;
            for (int k = 1; k < 6; k++) n_win[k] = r_win[k-1];
            n_phase = (r_phase == (r_len ? 3'd5 : 3'd3)) ? 3'd0 : r_phase + 3'd1;
            n_idx = r_idx + 6'd1;
            if (r_idx == w_total - 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        if (i_ctrl.start) r_len <= i_ctrl.len192;
        r_idx <= n_idx;
        r_phase <= n_phase;
        r_rc <= n_rc;
        for (int k = 0; k < 6; k++) r_win[k] <= n_win[k];
    end

    assign o_busy = r_busy;
    assign o_waddr = r_idx[AW-1:0];
endmodule
`default_nettype wire

// File: rtl/aes_cbc_block_cipher.sv
// Top level of the AES-128/192 block engine with optional CBC chaining.
`default_nettype none
// One 16-byte block per request. The round keys live in a memory of 128-bit
// rows, one row per round, with a registered read; the engine fetches the
// next round's row while it applies one full round per cycle, except that the
// final round waits while an older result still sits unread at the output.
// The load state applies the initial key addition, then the round state
// applies the rounds in order. The engine takes the next request in the cycle
// after it hands its result to the output register, and takes none while a
// block is in flight. A result that still waits in the output register holds
// the next block in its final round. Writing a key or the key length starts
// expansion of 44 or 52 words, one word per cycle; if the write comes while the
// engine is idle, requests are held off until it finishes. Registers: 0 key A,
// 1 key B, 2 key C, 3 key length, 4 decrypt, 5 chain enable, 6 IV high,
// 7 IV low, at byte address 8*i.
module aes_cbc_block_cipher #(
    parameter int unsigned ROUND_KEY_WORDS = 52
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // block_in_high, block_in_low
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // block_out_high, block_out_low
);
    localparam int unsigned AW = $clog2(ROUND_KEY_WORDS);
    localparam int unsigned ROWS = (ROUND_KEY_WORDS + 3) / 4;
    localparam int unsigned RW = $clog2(ROWS);

    logic [63:0] r_key_a, r_key_b, r_key_c, r_iv_hi, r_iv_lo;
    logic        r_len, r_dec, r_chain;
    logic [127:0] r_chain_blk;

    // Round-key memory kept as rows of four words, written word by word.
    logic [31:0] r_rk_mem [ROWS][4];
    logic [127:0] r_rk_q;
    logic [RW-1:0] w_rk_raddr;

    aescbc_pkg::t_state r_state, n_state;
    logic [3:0]   r_round, n_round;
    logic [127:0] r_s, n_s, r_in, r_out;
    logic         r_out_vld;
    logic         w_wr, w_kx_busy, w_kx_we, w_fire;
    logic [AW-1:0] w_kx_addr;
    logic [31:0]  w_kx_data;
    aescbc_pkg::t_kx_ctrl w_kx;
    logic [3:0]   w_nr;
    logic [127:0] w_sub, w_res;
    logic [2:0]   w_ridx;

    assign pready = 1'b1;
    assign w_wr = psel & penable & pwrite;
    assign w_ridx = paddr[5:3];
    assign w_nr = r_len ? 4'd12 : 4'd10;
    // Final round may write the result only when the output register is free.
    assign w_fire = (r_state == aescbc_pkg::ST_ROUND) && (r_round == w_nr)
                    && (!r_out_vld || m_axis_tready);

    always_comb begin
        w_kx.start = w_wr && (w_ridx == aescbc_pkg::REG_KEY_A || w_ridx == aescbc_pkg::REG_KEY_B
                     || w_ridx == aescbc_pkg::REG_KEY_C || w_ridx == aescbc_pkg::REG_KEY_LEN);
        w_kx.len192 = (w_ridx == aescbc_pkg::REG_KEY_LEN) ? pwdata[0] : r_len;
    end

    always_comb begin
        unique case (aescbc_pkg::t_reg_idx'(w_ridx))
            aescbc_pkg::REG_KEY_A:   prdata = r_key_a;
            aescbc_pkg::REG_KEY_B:   prdata = r_key_b;
            aescbc_pkg::REG_KEY_C:   prdata = r_key_c;
            aescbc_pkg::REG_KEY_LEN: prdata = {63'd0, r_len};
            aescbc_pkg::REG_DECRYPT: prdata = {63'd0, r_dec};
            aescbc_pkg::REG_CHAIN:   prdata = {63'd0, r_chain};
            aescbc_pkg::REG_IV_HI:   prdata = r_iv_hi;
            aescbc_pkg::REG_IV_LO:   prdata = r_iv_lo;
            default:                 prdata = '0;
        endcase
    end

    aescbc_kexp #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_kexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_kx),
        .i_key   ({(w_ridx == aescbc_pkg::REG_KEY_A && w_wr) ? pwdata : r_key_a,
                   (w_ridx == aescbc_pkg::REG_KEY_B && w_wr) ? pwdata : r_key_b,
                   (w_ridx == aescbc_pkg::REG_KEY_C && w_wr) ? pwdata : r_key_c}),
        .o_busy  (w_kx_busy),
        .o_we    (w_kx_we),
        .o_waddr (w_kx_addr),
        .o_wdata (w_kx_data)
    );

    // Round index to fetch next: encrypt counts up, decrypt counts down.
    always_comb begin
        w_rk_raddr = RW'(r_dec ? (w_nr - n_round) : n_round);
    end

    always_ff @(posedge i_clk) begin
        if (w_kx_we) r_rk_mem[w_kx_addr[AW-1:2]][w_kx_addr[1:0]] <= w_kx_data;
        r_rk_q <= {r_rk_mem[w_rk_raddr][0], r_rk_mem[w_rk_raddr][1],
                   r_rk_mem[w_rk_raddr][2], r_rk_mem[w_rk_raddr][3]};
    end

    always_comb begin
        w_sub = aescbc_pkg::sub_shift(r_s, r_dec);
        if (!r_dec) begin
            w_res = (r_round == w_nr) ? (w_sub ^ r_rk_q) : (aescbc_pkg::mix(w_sub, 1'b0) ^ r_rk_q);
        end else begin
            w_res = (r_round == w_nr) ? (w_sub ^ r_rk_q) : aescbc_pkg::mix(w_sub ^ r_rk_q, 1'b1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aescbc_pkg::ST_IDLE:  if (w_kx.start) n_state = aescbc_pkg::ST_KEXP;
                                  else if (s_axis_tvalid) n_state = aescbc_pkg::ST_LOAD;
            aescbc_pkg::ST_KEXP:  if (!w_kx_busy && !w_kx.start) n_state = aescbc_pkg::ST_IDLE;
            aescbc_pkg::ST_LOAD:  n_state = aescbc_pkg::ST_ROUND;
            aescbc_pkg::ST_ROUND: if (w_fire) n_state = aescbc_pkg::ST_IDLE;
            default:              n_state = aescbc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        n_round = r_round;
        n_s = r_s;
        unique case (r_state)
            aescbc_pkg::ST_IDLE:  n_round = 4'd0;
            aescbc_pkg::ST_LOAD:  begin
                n_s = (r_chain && !r_dec) ? (r_in ^ r_chain_blk) : r_in;
                n_s = n_s ^ r_rk_q;
                n_round = 4'd1;
            end
            aescbc_pkg::ST_ROUND: begin
                // Hold the final round while the previous result still waits.
                if (r_round != w_nr) begin
                    n_s = w_res;
                    n_round = r_round + 4'd1;
                end else if (w_fire) begin
                    n_s = w_res;
                    n_round = 4'd0;
                end
            end
            default: n_round = 4'd0;
        endcase
    end

    // Outputs.
    always_comb begin
        s_axis_tready = (r_state == aescbc_pkg::ST_IDLE) && !w_kx.start;
        m_axis_tvalid = r_out_vld;
        m_axis_tdata = {r_out[63:0], r_out[127:64]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aescbc_pkg::ST_IDLE;
            r_round <= 4'd0;
            r_out_vld <= 1'b0;
            r_key_a <= '0;
            r_key_b <= '0;
            r_key_c <= '0;
            r_len <= 1'b0;
            r_dec <= 1'b0;
            r_chain <= 1'b1;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
            r_chain_blk <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_wr) begin
                unique case (aescbc_pkg::t_reg_idx'(w_ridx))
                    aescbc_pkg::REG_KEY_A:   r_key_a <= pwdata;
                    aescbc_pkg::REG_KEY_B:   r_key_b <= pwdata;
                    aescbc_pkg::REG_KEY_C:   r_key_c <= pwdata;
                    aescbc_pkg::REG_KEY_LEN: r_len <= pwdata[0];
                    aescbc_pkg::REG_DECRYPT: r_dec <= pwdata[0];
                    aescbc_pkg::REG_CHAIN:   r_chain <= pwdata[0];
                    aescbc_pkg::REG_IV_HI:   begin
                        r_iv_hi <= pwdata;
                        r_chain_blk[127:64] <= pwdata;
                    end
                    aescbc_pkg::REG_IV_LO:   begin
                        r_iv_lo <= pwdata;
                        r_chain_blk[63:0] <= pwdata;
                    end
                    default: ;
                endcase
            end else if (w_fire && r_chain) begin
                // Advance the chain: ciphertext out on encrypt, ciphertext in on decrypt.
                r_chain_blk <= r_dec ? r_in : w_res;
            end
        end
        // Hold the block as {high, low}; high travels in the low half of tdata.
        if (s_axis_tvalid && s_axis_tready) r_in <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        r_s <= n_s;
        if (w_fire) begin
            r_out <= (r_dec && r_chain) ? (w_res ^ r_chain_blk) : w_res;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kx_busy |-> !s_axis_tready) else $error("request accepted during key expansion");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= 4'd13) else $error("round counter overrun");
`endif
endmodule
`default_nettype wire

// File: test/aes_cbc_block_checker.sv
// Checker for the AES CBC block engine: tracks registers, predicts and compares results.
module aes_cbc_block_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    input  wire logic         pready,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // block_in_high, block_in_low
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [127:0] m_axis_tdata,  // block_out_high, block_out_low
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } t_block;

    logic [7:0]  fwd_tab [256];
    logic [7:0]  inv_tab [256];
    logic [63:0] key_a, key_b, key_c;
    logic        len192, decrypt_on, chain_on;
    logic [63:0] chain_hi, chain_lo;
    logic [31:0] round_keys [52];
    t_block      expected_blocks [$];

    assign o_pending = expected_blocks.size();

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    // Rebuild the whole key schedule from the current key words and length.
    function automatic void expand_keys();
        logic [191:0] kbits;
        logic [31:0]  w [52];
        logic [31:0]  t;
        logic [7:0]   rc;
        int           nk, total;
        kbits = {key_a, key_b, key_c};
        nk = len192 ? 6 : 4;
        total = len192 ? 52 : 44;
        rc = 8'h01;
        for (int i = 0; i < 52; i++) begin
            if (i < nk) begin
                w[i] = kbits[191 - 32*i -: 32];
            end else if (i < total) begin
                t = w[i-1];
                if (i % nk == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]],
                         fwd_tab[t[7:0]]};
                    t ^= {rc, 24'h0};
                    rc = gf_dbl(rc);
                end
                w[i] = w[i-nk] ^ t;
            end
        end
        for (int i = 0; i < total; i++) round_keys[i] = w[i];
    endfunction

    // Byte i of a state sits at bits 127-8i.
    function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
        for (int i = 0; i < 16; i++)
            s[127 - 8*i -: 8] ^= round_keys[4*rnd + i/4][31 - 8*(i%4) -: 8];
        return s;
    endfunction

    function automatic logic [127:0] subst_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            if (inv) r[127 - 8*i -: 8] = inv_tab[s[127 - 8*((13*i) % 16) -: 8]];
            else     r[127 - 8*i -: 8] = fwd_tab[s[127 - 8*((5*i) % 16) -: 8]];
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] r;
        if (inv) begin
            coef[0] = 8'h0e; coef[1] = 8'h0b; coef[2] = 8'h0d; coef[3] = 8'h09;
        end else begin
            coef[0] = 8'h02; coef[1] = 8'h03; coef[2] = 8'h01; coef[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc ^= gf_mul(s[127 - 32*c - 8*j -: 8], coef[(j + 4 - row) % 4]);
                r[127 - 32*c - 8*row -: 8] = acc;
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] s, input logic inv);
        int nr;
        nr = len192 ? 12 : 10;
        if (!inv) begin
            s = add_key(s, 0);
            for (int r = 1; r < nr; r++) s = add_key(mix_cols(subst_rows(s, 1'b0), 1'b0), r);
            s = add_key(subst_rows(s, 1'b0), nr);
        end else begin
            s = add_key(s, nr);
            for (int r = nr - 1; r >= 1; r--)
                s = mix_cols(add_key(subst_rows(s, 1'b1), r), 1'b1);
            s = add_key(subst_rows(s, 1'b1), 0);
        end
        return s;
    endfunction

    // Build the S-boxes from the field inverse and the affine map.
    initial begin
        logic [7:0] v, b;
        for (int x = 0; x < 256; x++) begin
            v = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
            b = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
                ^ 8'h63;
            fwd_tab[x] = b;
            inv_tab[b] = 8'(x);
        end
        for (int i = 0; i < 52; i++) round_keys[i] = 32'h0;
    end

    always @(posedge i_clk) begin
        logic [127:0] st, res;
        logic [63:0]  hi, lo;
        t_block       got, want;
        if (!i_rst_n) begin
            key_a = '0; key_b = '0; key_c = '0;
            len192 = 1'b0; decrypt_on = 1'b0; chain_on = 1'b1;
            chain_hi = '0; chain_lo = '0;
            o_fail_count = 0;
        end else begin
            // Results first: an output is always older than a request taken at this edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_blocks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.high !== want.high || got.low !== want.low) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: high exp %h got %h, low exp %h got %h",
                                     want.high, got.high, want.low, got.low);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                hi = s_axis_tdata[63:0];
                lo = s_axis_tdata[127:64];
                if (!decrypt_on) begin
                    st = chain_on ? {hi ^ chain_hi, lo ^ chain_lo} : {hi, lo};
                    res = cipher_block(st, 1'b0);
                    if (chain_on) {chain_hi, chain_lo} = res;
                end else begin
                    res = cipher_block({hi, lo}, 1'b1);
                    if (chain_on) begin
                        res ^= {chain_hi, chain_lo};
                        chain_hi = hi;
                        chain_lo = lo;
                    end
                end
                want.high = res[127:64];
                want.low = res[63:0];
                expected_blocks.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (aescbc_pkg::t_reg_idx'(paddr[5:3]))
                    aescbc_pkg::REG_KEY_A:   begin key_a = pwdata; expand_keys(); end
                    aescbc_pkg::REG_KEY_B:   begin key_b = pwdata; expand_keys(); end
                    aescbc_pkg::REG_KEY_C:   begin key_c = pwdata; expand_keys(); end
                    aescbc_pkg::REG_KEY_LEN: begin len192 = pwdata[0]; expand_keys(); end
                    aescbc_pkg::REG_DECRYPT: decrypt_on = pwdata[0];
                    aescbc_pkg::REG_CHAIN:   chain_on = pwdata[0];
                    aescbc_pkg::REG_IV_HI:   chain_hi = pwdata;
                    aescbc_pkg::REG_IV_LO:   chain_lo = pwdata;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: test/tb_aes_cbc_block_cipher.sv
// Testbench top for the AES CBC block engine: stimulus, stalls and verdict.
module tb_aes_cbc_block_cipher;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // block_in_high, block_in_low
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;       // block_out_high, block_out_low
    int           fail_count;
    int           pending_blocks;
    int           blocks_sent;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           long_hold;

    aes_cbc_block_cipher dut (.*);

    aes_cbc_block_checker checker_inst (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending_blocks)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off that backs up the engine.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Register write: setup cycle, then access cycle; drop the select after the write edge.
    task automatic reg_write(input aescbc_pkg::t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drop the request on the accepting edge, then hold until every result is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_blocks != 0) @(negedge i_clk);
    endtask

    // Offer one request; ends on the edge that accepts it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        if (blocks_sent < 190) begin
            send_idle_pct = 25; recv_idle_pct = 50;
        end else if (blocks_sent < 380) begin
            send_idle_pct = 50; recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
        end
        if (blocks_sent == 250) long_hold = 1'b1;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lo, hi};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        blocks_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(input int nblocks, input int flavor);
        logic [63:0] kv, ivv;
        wait_drained();
        // Extremes first: all-ones keys and IV, then all zeros, then random.
        kv = (flavor == 0) ? '1 : (flavor == 1) ? '0 : rand64();
        ivv = (flavor == 0) ? '1 : (flavor == 1) ? '0 : rand64();
        reg_write(aescbc_pkg::REG_KEY_LEN, (flavor < 2) ? 64'(flavor) : rand64());
        reg_write(aescbc_pkg::REG_KEY_A, kv);
        reg_write(aescbc_pkg::REG_KEY_B, (flavor < 2) ? kv : rand64());
        reg_write(aescbc_pkg::REG_KEY_C, (flavor < 2) ? kv : rand64());
        reg_write(aescbc_pkg::REG_DECRYPT, rand64());
        reg_write(aescbc_pkg::REG_CHAIN, (flavor < 2) ? 64'h1 : rand64());
        reg_write(aescbc_pkg::REG_IV_HI, ivv);
        reg_write(aescbc_pkg::REG_IV_LO, (flavor < 2) ? ivv : rand64());
        for (int n = 0; n < nblocks; n++) begin
            case ($urandom_range(9))
                0:       send_block('0, '0);
                1:       send_block('1, '1);
                default: send_block(rand64(), rand64());
            endcase
        end
    endtask

    initial begin
        blocks_sent = 0;
        send_idle_pct = 25;
        recv_idle_pct = 50;
        long_hold = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Known-answer start: 128-bit key in ECB, then the same in decrypt.
        reg_write(aescbc_pkg::REG_KEY_A, 64'h0001020304050607);
        reg_write(aescbc_pkg::REG_KEY_B, 64'h08090a0b0c0d0e0f);
        reg_write(aescbc_pkg::REG_CHAIN, 64'h0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '0);
        send_block('1, '1);
        wait_drained();
        // Wide value into a one-bit register keeps only bit 0.
        reg_write(aescbc_pkg::REG_DECRYPT, 64'hffff_ffff_ffff_ffff);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block('1, '1);
        wait_drained();
        // Third key word in 128-bit mode must leave the round keys alone.
        reg_write(aescbc_pkg::REG_KEY_C, 64'h1011121314151617);
        reg_write(aescbc_pkg::REG_CHAIN, 64'hffff_ffff_0000_0003);
        reg_write(aescbc_pkg::REG_IV_HI, 64'h0001020304050607);
        reg_write(aescbc_pkg::REG_IV_LO, 64'h08090a0b0c0d0e0f);
        send_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d);
        send_block(64'h5086cb9b507219ee, 64'h95db113a917678b2);
        wait_drained();
        reg_write(aescbc_pkg::REG_DECRYPT, 64'h2);
        reg_write(aescbc_pkg::REG_IV_HI, 64'h0001020304050607);
        reg_write(aescbc_pkg::REG_IV_LO, 64'h08090a0b0c0d0e0f);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
        send_block('0, '0);
        send_block('1, '1);
        wait_drained();
        // Switch to a 192-bit key: length change re-expands the stored words.
        reg_write(aescbc_pkg::REG_KEY_LEN, 64'h1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '0);
        send_block('1, '1);
        wait_drained();
        reg_write(aescbc_pkg::REG_DECRYPT, 64'h1);
        send_block(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        send_block('1, '0);
        send_block('0, '1);
        wait_drained();
        reg_write(aescbc_pkg::REG_KEY_LEN, 64'h0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block('1, '1);

        for (int p = 0; p < 11; p++) random_phase(50, p);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_blocks == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
